@@ rtl/ispu_pkg.sv @@
// ----------------------------------------------------------------------------
// ispu_pkg: shared types and constants of the interpolating sample player
// field widths, item and register codes, controller/datapath interface
// ----------------------------------------------------------------------------
package ispu_pkg;

	localparam int KIND_W     = 2;
	localparam int LOAD_ADR_W = 16;
	localparam int SMP_W      = 16;
	localparam int MIX_W      = 24;
	localparam int LEN_W      = 17;
	localparam int RATE_W     = 19;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 19;
	// integer bits of the play position: length plus one step stays below 2^18
	localparam int POS_INT_W  = 18;

	localparam logic [RATE_W-1:0] RATE_RESET = 19'd65536;

	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD    = 2'd0,
		KIND_RENDER  = 2'd1,
		KIND_RESTART = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LENGTH = 2'd0,
		CFG_STEREO = 2'd1,
		CFG_RATE   = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic take;       // item beat accepted this cycle
		logic rd_hi;      // address the store with the upper frame
		logic cap_e0;     // capture the lower frame
		logic cap_mul;    // capture the products
		logic push_pend;  // load output from the pending result
		logic push_calc;  // load output from the interpolated sum
	} ispu_cmd_t;

	typedef struct packed {
		logic go;         // render item needs the store and interpolation
	} ispu_status_t;

endpackage

@@ rtl/ispu_ctrl.sv @@
// ----------------------------------------------------------------------------
// ispu_ctrl: sequencing controller of the sample player
// steps one item through read, multiply and sum, owns the handshakes
// ----------------------------------------------------------------------------
module ispu_ctrl import ispu_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  logic         out_ready,
	input  ispu_status_t status,
	output ispu_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD1,
		ST_MUL,
		ST_ADD,
		ST_PUSH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.take      = (state_q == ST_IDLE) && in_valid;
		cmd.rd_hi     = (state_q == ST_RD1);
		cmd.cap_e0    = (state_q == ST_RD1);
		cmd.cap_mul   = (state_q == ST_MUL);
		cmd.push_calc = (state_q == ST_ADD) && out_free;
		cmd.push_pend = (state_q == ST_PUSH) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.push_calc || cmd.push_pend)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= status.go ? ST_RD1 : ST_PUSH;
				end
				ST_RD1:  state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_ADD;
				ST_ADD: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				ST_PUSH: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/ispu_datapath.sv @@
// ----------------------------------------------------------------------------
// ispu_datapath: sample store, play position and interpolation arithmetic
// single-port store, two multiply lanes, saturating mix adders
// ----------------------------------------------------------------------------
module ispu_datapath import ispu_pkg::*; #(
	parameter int SAMPLE_DEPTH = 65536,
	parameter int FRAC_BITS    = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ispu_cmd_t                    cmd,
	output ispu_status_t                 status,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,
	input  logic [KIND_W-1:0]            kind,
	input  logic [LOAD_ADR_W-1:0]        load_address,
	input  logic signed [SMP_W-1:0]      load_left,
	input  logic signed [SMP_W-1:0]      load_right,
	input  logic signed [MIX_W-1:0]      mix_left,
	input  logic signed [MIX_W-1:0]      mix_right,
	output logic signed [MIX_W-1:0]      out_left,
	output logic signed [MIX_W-1:0]      out_right,
	output logic                         voice_done
);

	localparam int ADDR_W = $clog2(SAMPLE_DEPTH);
	localparam int POS_W  = POS_INT_W + FRAC_BITS;
	localparam int IDX_W  = ((ADDR_W > POS_INT_W) ? ADDR_W : POS_INT_W) + 2;
	localparam int DIFF_W = SMP_W + 1;
	localparam int PROD_W = DIFF_W + FRAC_BITS + 1;
	localparam int SHR_W  = PROD_W - FRAC_BITS;
	localparam int VAL_W  = SMP_W + 3;
	localparam int SUM_W  = MIX_W + 1;
	localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(SAMPLE_DEPTH);

	function automatic logic signed [MIX_W-1:0] sat_mix(input logic signed [SUM_W-1:0] s);
		logic signed [MIX_W-1:0] r;
		if (s[SUM_W-1] != s[SUM_W-2])
			r = s[SUM_W-1] ? {1'b1, {(MIX_W-1){1'b0}}} : {1'b0, {(MIX_W-1){1'b1}}};
		else
			r = s[MIX_W-1:0];
		return r;
	endfunction

	// configuration
	logic [LEN_W-1:0]  length_q;
	logic              stereo_q;
	logic [RATE_W-1:0] rate_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= '0;
			stereo_q <= 1'b0;
			rate_q   <= RATE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LENGTH: length_q <= cfg_data[LEN_W-1:0];
				CFG_STEREO: stereo_q <= cfg_data[0];
				CFG_RATE:   rate_q   <= cfg_data[RATE_W-1:0];
				default:    ;
			endcase
		end
	end

	// voice state
	logic [POS_W-1:0]     pos_q, pos_d, pos_nxt;
	logic                 done_q, done_d;
	logic [POS_INT_W-1:0] pos_int;
	logic [POS_INT_W:0]   pos_p1;
	logic                 end_hit, adv_done;
	logic                 is_load, is_render, is_restart;

	assign pos_int    = pos_q[POS_W-1:FRAC_BITS];
	assign pos_p1     = (POS_INT_W+1)'(pos_int) + (POS_INT_W+1)'(1);
	assign end_hit    = pos_p1 >= (POS_INT_W+1)'(length_q);
	assign pos_nxt    = pos_q + POS_W'(rate_q);
	assign adv_done   = pos_nxt[POS_W-1:FRAC_BITS] >= POS_INT_W'(length_q);
	assign is_load    = (kind == KIND_LOAD);
	assign is_render  = (kind == KIND_RENDER);
	assign is_restart = (kind == KIND_RESTART);
	assign status.go  = is_render && !done_q && !end_hit;

	always_comb begin
		pos_d  = pos_q;
		done_d = done_q;
		if (is_restart) begin
			pos_d  = '0;
			done_d = 1'b0;
		end else if (is_render && !done_q) begin
			if (end_hit) begin
				done_d = 1'b1;
			end else begin
				pos_d  = pos_nxt;
				done_d = adv_done;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			done_q <= 1'b0;
		end else if (cmd.take) begin
			pos_q  <= pos_d;
			done_q <= done_d;
		end
	end

	// item capture
	logic signed [MIX_W-1:0] pend_l_q, pend_r_q, mix_l_q, mix_r_q;
	logic                    pend_done_q;
	logic [FRAC_BITS-1:0]    frac_q;
	logic [IDX_W-1:0]        idx_hi_q;
	logic                    ok_lo_q, ok_hi_q;

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			pend_l_q    <= is_render ? mix_left : '0;
			pend_r_q    <= is_render ? mix_right : '0;
			pend_done_q <= done_d;
			mix_l_q     <= mix_left;
			mix_r_q     <= mix_right;
			frac_q      <= pos_q[FRAC_BITS-1:0];
			idx_hi_q    <= IDX_W'(pos_p1);
			ok_lo_q     <= IDX_W'(pos_int) < DEPTH_IDX;
			ok_hi_q     <= IDX_W'(pos_p1) < DEPTH_IDX;
		end
	end

	// sample store, right in the upper half
	logic [2*SMP_W-1:0] mem [0:SAMPLE_DEPTH-1];
	logic [2*SMP_W-1:0] rdata_q;
	logic [IDX_W-1:0]   load_idx, rd_idx, mem_idx;
	logic [ADDR_W-1:0]  mem_addr;
	logic               mem_we;

	assign load_idx = IDX_W'(load_address);
	assign mem_we   = cmd.take && is_load && (load_idx < DEPTH_IDX);
	assign rd_idx   = cmd.rd_hi ? idx_hi_q : IDX_W'(pos_int);
	assign mem_idx  = mem_we ? load_idx : rd_idx;
	assign mem_addr = mem_idx[ADDR_W-1:0];

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_addr] <= {load_right, load_left};
		rdata_q <= mem[mem_addr];
	end

	// multiply lanes
	logic [2*SMP_W-1:0]       e0_q, e1;
	logic signed [SMP_W-1:0]  a_l, a_r, b_l, b_r;
	logic signed [DIFF_W-1:0] diff_l, diff_r;
	logic signed [FRAC_BITS:0] frac_s;
	logic signed [PROD_W-1:0] prod_l, prod_r, prod_l_q, prod_r_q;

	assign e1     = ok_hi_q ? rdata_q : '0;
	assign a_l    = e0_q[SMP_W-1:0];
	assign a_r    = e0_q[2*SMP_W-1:SMP_W];
	assign b_l    = e1[SMP_W-1:0];
	assign b_r    = e1[2*SMP_W-1:SMP_W];
	assign diff_l = DIFF_W'(b_l) - DIFF_W'(a_l);
	assign diff_r = DIFF_W'(b_r) - DIFF_W'(a_r);
	assign frac_s = $signed({1'b0, frac_q});
	assign prod_l = diff_l * frac_s;
	assign prod_r = diff_r * frac_s;

	always_ff @(posedge clk) begin
		if (cmd.cap_e0)
			e0_q <= ok_lo_q ? rdata_q : '0;
		if (cmd.cap_mul) begin
			prod_l_q <= prod_l;
			prod_r_q <= prod_r;
		end
	end

	// interpolate, add onto the mix, saturate
	logic signed [SHR_W-1:0] shr_l, shr_r;
	logic signed [VAL_W-1:0] v_l, v_r, v_rs;
	logic signed [SUM_W-1:0] sum_l, sum_r;

	assign shr_l = prod_l_q[PROD_W-1:FRAC_BITS];
	assign shr_r = prod_r_q[PROD_W-1:FRAC_BITS];
	assign v_l   = VAL_W'(a_l) + VAL_W'(shr_l);
	assign v_r   = VAL_W'(a_r) + VAL_W'(shr_r);
	assign v_rs  = stereo_q ? v_r : v_l;
	assign sum_l = SUM_W'(mix_l_q) + SUM_W'(v_l);
	assign sum_r = SUM_W'(mix_r_q) + SUM_W'(v_rs);

	// output register
	logic signed [MIX_W-1:0] out_l_q, out_r_q;
	logic                    out_done_q;

	always_ff @(posedge clk) begin
		if (cmd.push_pend) begin
			out_l_q    <= pend_l_q;
			out_r_q    <= pend_r_q;
			out_done_q <= pend_done_q;
		end else if (cmd.push_calc) begin
			out_l_q    <= sat_mix(sum_l);
			out_r_q    <= sat_mix(sum_r);
			out_done_q <= done_q;
		end
	end

	assign out_left   = out_l_q;
	assign out_right  = out_r_q;
	assign voice_done = out_done_q;

endmodule

@@ rtl/interpolating_sample_player_unit.sv @@
// ----------------------------------------------------------------------------
// interpolating_sample_player_unit: one-voice linear interpolating player
// loads a sample store, renders frames at a fractional rate onto a mix
// ----------------------------------------------------------------------------
//
// channel  direction  handshake              payload
// -------  ---------  ---------------------  -----------------------------------
// item     in         in_valid / in_ready    kind, load_address, load_left,
//                                            load_right, mix_left, mix_right
// result   out        out_valid / out_ready  out_left, out_right, voice_done
// config   in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a playing render beat steps through accept (read frame p), read frame p+1,
// multiply, add and saturate; the single-port store forces the two reads apart
// load, restart, unused and passing render beats step through accept, result
// one item is in flight at a time; the result register holds a finished beat
// while the next item is accepted, and only the final push waits on out_ready
// reset clears position, done flag, config (rate to 1.0) and the result valid;
// the sample store is not cleared
// config beats are always taken; write only while no item is in flight
//
module interpolating_sample_player_unit import ispu_pkg::*; #(
	parameter int SAMPLE_DEPTH = 65536,
	parameter int FRAC_BITS    = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// item channel
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [KIND_W-1:0]       kind,
	input  logic [LOAD_ADR_W-1:0]   load_address,
	input  logic signed [SMP_W-1:0] load_left,
	input  logic signed [SMP_W-1:0] load_right,
	input  logic signed [MIX_W-1:0] mix_left,
	input  logic signed [MIX_W-1:0] mix_right,
	// result channel
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [MIX_W-1:0] out_left,
	output logic signed [MIX_W-1:0] out_right,
	output logic                    voice_done,
	// config channel
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data
);

	ispu_cmd_t    cmd;
	ispu_status_t status;

	// register writes are always accepted, no back-pressure needed; a write to an unused index is dropped
	assign cfg_ready = 1'b1;

	// state machine: handshakes and step sequencing
	ispu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// store, position, interpolation and result register
	ispu_datapath #(
		.SAMPLE_DEPTH (SAMPLE_DEPTH),
		.FRAC_BITS    (FRAC_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.kind         (kind),
		.load_address (load_address),
		.load_left    (load_left),
		.load_right   (load_right),
		.mix_left     (mix_left),
		.mix_right    (mix_right),
		.out_left     (out_left),
		.out_right    (out_right),
		.voice_done   (voice_done)
	);

endmodule

@@ rtl/ispu_checker.sv @@
// ----------------------------------------------------------------------------
// ispu_checker: port-level checks of the sample player
// result stability, one item in flight, results only after work
// ----------------------------------------------------------------------------
module ispu_checker import ispu_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic signed [MIX_W-1:0] out_left,
	input logic signed [MIX_W-1:0] out_right,
	input logic                    voice_done
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_left) &&
			$stable(out_right) && $stable(voice_done))
		else $error("result beat changed while stalled");

	// an accepted item drops in_ready, so no two items are accepted back to back
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted back to back");

	// a new result only follows a cycle in which the block was busy
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared without an item in flight");

endmodule

bind interpolating_sample_player_unit ispu_checker u_ispu_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.out_left   (out_left),
	.out_right  (out_right),
	.voice_done (voice_done)
);
